// ===== rtl/ngga_pkg.sv =====
// Shared constants, types and helpers for the GGA sentence parser.
// No dependencies; imported by ngga_dec and nmea_gga_sentence_parser.
package ngga_pkg;

	// Longest field prefix that is looked at, and the cap on the char counter
	localparam int FIELD_CHARS = 16;
	localparam int CPOS_W      = 5;
	localparam int CHAR_CAP    = (FIELD_CHARS < 31) ? FIELD_CHARS : 31;

	// Decimal accumulators: magnitude in tenths, wide enough for the altitude limit
	localparam int ACC_W = 20;
	localparam logic [ACC_W-1:0] LIM_HDOP  = ACC_W'(9999);
	localparam logic [ACC_W-1:0] LIM_ALT   = ACC_W'(1000000);
	localparam logic [ACC_W-1:0] LIM_GEOID = ACC_W'(100000);

	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_COMMA  = 8'h2C;
	localparam logic [7:0] CHR_MINUS  = 8'h2D;
	localparam logic [7:0] CHR_PLUS   = 8'h2B;
	localparam logic [7:0] CHR_DOT    = 8'h2E;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_NINE   = 8'h39;
	localparam logic [7:0] CHR_S      = 8'h53;
	localparam logic [7:0] CHR_W      = 8'h57;

	// Per-character control for one decimal field decoder
	typedef struct packed {
		logic clr;    // sentence restart
		logic en;     // character belongs to this field and is within the cap
		logic first;  // character is the first of its field
	} dec_ctrl_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHR_ZERO) && (b <= CHR_NINE);
	endfunction

	function automatic logic [3:0] digit_of(input logic [7:0] b);
		logic [7:0] d;
		d = b - CHR_ZERO;
		return is_digit(b) ? d[3:0] : 4'd0;
	endfunction

endpackage

// ===== rtl/nmea_gga_sentence_parser.sv =====
// GGA sentence parser: takes one received character per transfer and delivers one decoded
// fix per "$GPGGA ... *" sentence. A character is taken every cycle while in_stall is low;
// it is registered, then decoded against the sentence state, and the '*' that closes a
// sentence loads the result register, so a fix passes the input and result registers. A
// result waiting at the output holds back input only when the next '*' reaches the decode
// stage. Only the first 16 characters of each field are used; a '$' always restarts.
// Depends on ngga_pkg and ngga_dec.
module nmea_gga_sentence_parser
	import ngga_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [6:0]          utc_hour,
	output logic [6:0]          utc_minute,
	output logic [6:0]          utc_second,
	output logic [6:0]          lat_degrees,
	output logic [19:0]         lat_minutes_e4,
	output logic                lat_south,
	output logic [9:0]          lon_degrees,
	output logic [19:0]         lon_minutes_e4,
	output logic                lon_west,
	output logic [13:0]         hdop_tenths,
	output logic signed [20:0]  altitude_tenths,
	output logic signed [17:0]  geoid_tenths
);

	typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_BODY} phase_t;

	localparam logic [3:0] FLD_TIME  = 4'd0;
	localparam logic [3:0] FLD_LAT   = 4'd1;
	localparam logic [3:0] FLD_NS    = 4'd2;
	localparam logic [3:0] FLD_LON   = 4'd3;
	localparam logic [3:0] FLD_EW    = 4'd4;
	localparam logic [3:0] FLD_HDOP  = 4'd7;
	localparam logic [3:0] FLD_ALT   = 4'd8;
	localparam logic [3:0] FLD_GEOID = 4'd10;
	localparam logic [3:0] FLD_LAST  = 4'd15;
	localparam logic [2:0] HDR_LEN   = 3'd6;
	localparam int         NUM_SLOTS = 23;
	localparam int         SLOT_W    = 5;

	// header text "$GPGGA", entry 0 first
	localparam logic [7:0] HDR_TEXT [6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};

	phase_t            phase_q;
	logic [2:0]        hpos_q;
	logic [3:0]        field_q;
	logic [CPOS_W-1:0] cpos_q;
	logic              south_q, west_q;
	logic [3:0]        digits_q [NUM_SLOTS];

	logic              valid_s1;
	logic [7:0]        byte_s1;

	logic              out_valid_q;
	logic [6:0]        hour_q, minute_q, second_q, lat_deg_q;
	logic [19:0]       lat_min_q, lon_min_q;
	logic [9:0]        lon_deg_q;
	logic              lat_south_q, lon_west_q;
	logic [13:0]       hdop_q;
	logic [20:0]       alt_q;
	logic [17:0]       geoid_q;

	logic              is_dollar, is_star, is_comma;
	logic              emit_s1, go_s1, body_chr, in_cap;
	logic              slot_we;
	logic [SLOT_W-1:0] slot_idx;
	logic [3:0]        dig_s1;

	dec_ctrl_t         hdop_ctrl, alt_ctrl, geoid_ctrl;
	logic [ACC_W-1:0]  hdop_acc, alt_acc, geoid_acc;
	logic              hdop_neg, alt_neg, geoid_neg;

	assign is_dollar = (byte_s1 == CHR_DOLLAR);
	assign is_star   = (byte_s1 == CHR_STAR);
	assign is_comma  = (byte_s1 == CHR_COMMA);
	assign dig_s1    = digit_of(byte_s1);

	assign emit_s1  = valid_s1 && !is_dollar && is_star && (phase_q == PH_BODY);
	// the decode stage only waits when it must load a result over one not yet taken
	assign go_s1    = valid_s1 && !(emit_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go_s1;

	assign in_cap   = (cpos_q < CPOS_W'(CHAR_CAP));
	assign body_chr = go_s1 && (phase_q == PH_BODY) && !is_dollar && !is_star && !is_comma;

	// fixed digit slots: time 0..5, latitude 6..13, longitude 14..22
	always_comb begin
		slot_we  = 1'b0;
		slot_idx = '0;
		if (body_chr && in_cap) begin
			unique case (field_q)
				FLD_TIME: begin
					if (cpos_q < CPOS_W'(6)) begin
						slot_we  = 1'b1;
						slot_idx = SLOT_W'(cpos_q);
					end
				end
				FLD_LAT: begin
					if (cpos_q < CPOS_W'(4)) begin
						slot_we  = 1'b1;
						slot_idx = SLOT_W'(cpos_q) + SLOT_W'(6);
					end else if (cpos_q >= CPOS_W'(5) && cpos_q <= CPOS_W'(8)) begin
						slot_we  = 1'b1;
						slot_idx = SLOT_W'(cpos_q) + SLOT_W'(5);
					end
				end
				FLD_LON: begin
					if (cpos_q < CPOS_W'(5)) begin
						slot_we  = 1'b1;
						slot_idx = SLOT_W'(cpos_q) + SLOT_W'(14);
					end else if (cpos_q >= CPOS_W'(6) && cpos_q <= CPOS_W'(9)) begin
						slot_we  = 1'b1;
						slot_idx = SLOT_W'(cpos_q) + SLOT_W'(13);
					end
				end
				default: begin
					slot_we  = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		hdop_ctrl.clr    = go_s1 && is_dollar;
		hdop_ctrl.en     = body_chr && in_cap && (field_q == FLD_HDOP);
		hdop_ctrl.first  = (cpos_q == '0);
		alt_ctrl.clr     = hdop_ctrl.clr;
		alt_ctrl.en      = body_chr && in_cap && (field_q == FLD_ALT);
		alt_ctrl.first   = hdop_ctrl.first;
		geoid_ctrl.clr   = hdop_ctrl.clr;
		geoid_ctrl.en    = body_chr && in_cap && (field_q == FLD_GEOID);
		geoid_ctrl.first = hdop_ctrl.first;
	end

	ngga_dec u_dec_hdop (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hdop_ctrl),
		.rx_byte (byte_s1),
		.limit   (LIM_HDOP),
		.acc     (hdop_acc),
		.neg     (hdop_neg)
	);

	ngga_dec u_dec_alt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (alt_ctrl),
		.rx_byte (byte_s1),
		.limit   (LIM_ALT),
		.acc     (alt_acc),
		.neg     (alt_neg)
	);

	ngga_dec u_dec_geoid (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (geoid_ctrl),
		.rx_byte (byte_s1),
		.limit   (LIM_GEOID),
		.acc     (geoid_acc),
		.neg     (geoid_neg)
	);

	// sentence control, input stage valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hpos_q      <= '0;
			field_q     <= '0;
			cpos_q      <= '0;
			south_q     <= 1'b0;
			west_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end

			if (emit_s1 && go_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (go_s1) begin
				if (is_dollar) begin
					phase_q <= PH_HEAD;
					hpos_q  <= 3'd1;
					field_q <= '0;
					cpos_q  <= '0;
					south_q <= 1'b0;
					west_q  <= 1'b0;
				end else begin
					unique case (phase_q)
						PH_HEAD: begin
							// byte after the header text is its separator, whatever it is
							if (hpos_q >= HDR_LEN) begin
								phase_q <= PH_BODY;
								hpos_q  <= '0;
							end else if (byte_s1 == HDR_TEXT[hpos_q]) begin
								hpos_q <= hpos_q + 3'd1;
							end else begin
								phase_q <= PH_IDLE;
								hpos_q  <= '0;
							end
						end
						PH_BODY: begin
							if (is_star) begin
								phase_q <= PH_IDLE;
							end else if (is_comma) begin
								if (field_q != FLD_LAST) begin
									field_q <= field_q + 4'd1;
								end
								cpos_q <= '0;
							end else if (in_cap) begin
								cpos_q <= cpos_q + CPOS_W'(1);
								if (cpos_q == '0 && field_q == FLD_NS && byte_s1 == CHR_S) begin
									south_q <= 1'b1;
								end
								if (cpos_q == '0 && field_q == FLD_EW && byte_s1 == CHR_W) begin
									west_q <= 1'b1;
								end
							end
						end
						default: begin
							phase_q <= PH_IDLE;
						end
					endcase
				end
			end
		end
	end

	// input register and digit store
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (go_s1 && is_dollar) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				digits_q[i] <= '0;
			end
		end else if (slot_we) begin
			digits_q[slot_idx] <= dig_s1;
		end
	end

	// result register, loaded on the closing '*'
	always_ff @(posedge clk) begin
		if (emit_s1 && go_s1) begin
			hour_q      <= 7'(digits_q[0]) * 7'd10 + 7'(digits_q[1]);
			minute_q    <= 7'(digits_q[2]) * 7'd10 + 7'(digits_q[3]);
			second_q    <= 7'(digits_q[4]) * 7'd10 + 7'(digits_q[5]);
			lat_deg_q   <= 7'(digits_q[6]) * 7'd10 + 7'(digits_q[7]);
			lat_min_q   <= 20'(digits_q[8]) * 20'd100000 + 20'(digits_q[9]) * 20'd10000
			             + 20'(digits_q[10]) * 20'd1000 + 20'(digits_q[11]) * 20'd100
			             + 20'(digits_q[12]) * 20'd10 + 20'(digits_q[13]);
			lat_south_q <= south_q;
			lon_deg_q   <= 10'(digits_q[14]) * 10'd100 + 10'(digits_q[15]) * 10'd10
			             + 10'(digits_q[16]);
			lon_min_q   <= 20'(digits_q[17]) * 20'd100000 + 20'(digits_q[18]) * 20'd10000
			             + 20'(digits_q[19]) * 20'd1000 + 20'(digits_q[20]) * 20'd100
			             + 20'(digits_q[21]) * 20'd10 + 20'(digits_q[22]);
			lon_west_q  <= west_q;
			// negative HDOP reads as zero
			hdop_q      <= hdop_neg ? 14'd0 : hdop_acc[13:0];
			alt_q       <= alt_neg ? (21'd0 - 21'(alt_acc)) : 21'(alt_acc);
			geoid_q     <= geoid_neg ? (18'd0 - geoid_acc[17:0]) : geoid_acc[17:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign utc_hour        = hour_q;
	assign utc_minute      = minute_q;
	assign utc_second      = second_q;
	assign lat_degrees     = lat_deg_q;
	assign lat_minutes_e4  = lat_min_q;
	assign lat_south       = lat_south_q;
	assign lon_degrees     = lon_deg_q;
	assign lon_minutes_e4  = lon_min_q;
	assign lon_west        = lon_west_q;
	assign hdop_tenths     = hdop_q;
	assign altitude_tenths = alt_q;
	assign geoid_tenths    = geoid_q;

endmodule

// ===== rtl/ngga_dec.sv =====
// Signed decimal field decoder: magnitude in tenths with saturation, sign and stop flags.
// Depends on ngga_pkg.
module ngga_dec
	import ngga_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  dec_ctrl_t        ctrl,
	input  logic [7:0]       rx_byte,
	input  logic [ACC_W-1:0] limit,
	output logic [ACC_W-1:0] acc,
	output logic             neg
);

	logic [ACC_W-1:0] acc_q, acc_n;
	logic             neg_q, neg_n;
	logic             point_q, point_n;
	logic             stop_q, stop_n;
	logic [3:0]       dig;
	logic [23:0]      times10;
	logic [ACC_W:0]   plus_tenth;

	assign dig        = digit_of(rx_byte);
	assign times10    = 24'(acc_q) * 24'd10 + 24'(dig) * 24'd10;
	assign plus_tenth = (ACC_W+1)'(acc_q) + (ACC_W+1)'(dig);

	always_comb begin
		acc_n   = acc_q;
		neg_n   = neg_q;
		point_n = point_q;
		stop_n  = stop_q;
		if (!stop_q) begin
			priority if (ctrl.first && (rx_byte == CHR_MINUS || rx_byte == CHR_PLUS)) begin
				neg_n = neg_q | (rx_byte == CHR_MINUS);
			end else if (point_q) begin
				// tenths digit; anything after it is truncated
				if (is_digit(rx_byte)) begin
					acc_n = (plus_tenth > (ACC_W+1)'(limit)) ? limit : plus_tenth[ACC_W-1:0];
				end
				stop_n = 1'b1;
			end else if (rx_byte == CHR_DOT) begin
				point_n = 1'b1;
			end else if (is_digit(rx_byte)) begin
				acc_n = (times10 > 24'(limit)) ? limit : times10[ACC_W-1:0];
			end else begin
				stop_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			point_q <= 1'b0;
			stop_q  <= 1'b0;
		end else if (ctrl.clr) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			point_q <= 1'b0;
			stop_q  <= 1'b0;
		end else if (ctrl.en) begin
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			point_q <= point_n;
			stop_q  <= stop_n;
		end
	end

	assign acc = acc_q;
	assign neg = neg_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for nmea_gga_sentence_parser: GGA sentences, broken headers and
// line noise go in byte by byte, and each decoded fix is checked against a decoder kept here.
// Depends on ngga_pkg (character codes, field cap) and the parser RTL.
module tb_top;
	import ngga_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 500;
	localparam int RANDOM_FIXES = 5;
	localparam int SHOWN_ERRORS = 10;
	localparam logic [47:0] GGA_TAG = "$GPGGA";
	localparam logic [7:0] CHR_CR = 8'h0D;

	// body field numbers, time field is 0
	localparam int FLD_TIME  = 0;
	localparam int FLD_LAT   = 1;
	localparam int FLD_NS    = 2;
	localparam int FLD_LON   = 3;
	localparam int FLD_EW    = 4;
	localparam int FLD_HDOP  = 7;
	localparam int FLD_ALT   = 8;
	localparam int FLD_GEOID = 10;
	localparam int FLD_LAST  = 15;

	localparam int DEC_HDOP  = 0;
	localparam int DEC_ALT   = 1;
	localparam int DEC_GEOID = 2;

	typedef enum logic [1:0] {WAIT_DOLLAR, IN_HEADER, IN_BODY} phase_t;

	typedef struct packed {
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [6:0]  lat_deg;
		logic [19:0] lat_min;
		logic        south;
		logic [9:0]  lon_deg;
		logic [19:0] lon_min;
		logic        west;
		logic [13:0] hdop;
		logic [20:0] alt;
		logic [17:0] geoid;
	} fix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  utc_hour, utc_minute, utc_second, lat_degrees;
	logic [19:0] lat_minutes_e4, lon_minutes_e4;
	logic        lat_south, lon_west;
	logic [9:0]  lon_degrees;
	logic [13:0] hdop_tenths;
	logic signed [20:0] altitude_tenths;
	logic signed [17:0] geoid_tenths;

	nmea_gga_sentence_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.utc_hour(utc_hour),
		.utc_minute(utc_minute),
		.utc_second(utc_second),
		.lat_degrees(lat_degrees),
		.lat_minutes_e4(lat_minutes_e4),
		.lat_south(lat_south),
		.lon_degrees(lon_degrees),
		.lon_minutes_e4(lon_minutes_e4),
		.lon_west(lon_west),
		.hdop_tenths(hdop_tenths),
		.altitude_tenths(altitude_tenths),
		.geoid_tenths(geoid_tenths)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state
	phase_t      phase;
	int unsigned hdr_pos, field_idx, char_idx;
	logic [3:0]  dig [26];
	bit          south_seen, west_seen;
	int unsigned dec_mag [3];
	bit          dec_neg [3], dec_point [3], dec_done [3];

	fix_t        fix_q [$];
	fix_t        got_fix, want_fix;
	logic [7:0]  line_q [$];
	int          fixes_made = 0, fixes_seen = 0, bytes_sent = 0;
	int          errors = 0, cycle_count = 0, stall_run = 0;
	bit          idling = 1'b0, holding = 1'b0;
	string       bad_fields;
	event        hold_go;

	function automatic logic [3:0] digit_val(input logic [7:0] b);
		return (b >= CHR_ZERO && b <= CHR_NINE) ? 4'(b - CHR_ZERO) : 4'd0;
	endfunction

	function automatic int unsigned dec_cap(input int k);
		case (k)
			DEC_HDOP: return 9999;
			DEC_ALT:  return 1000000;
			default:  return 100000;
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		if (!idling)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic string fix_text(input fix_t f);
		return $sformatf("utc %0d:%0d:%0d lat %0d %0d s%0d lon %0d %0d w%0d hdop %0d alt %0d geoid %0d",
			f.hour, f.minute, f.second, f.lat_deg, f.lat_min, f.south, f.lon_deg,
			f.lon_min, f.west, f.hdop, $signed(f.alt), $signed(f.geoid));
	endfunction

	function automatic fix_t current_fix();
		fix_t f;
		int   a, g;
		f.hour    = 7'(dig[0] * 10 + dig[1]);
		f.minute  = 7'(dig[2] * 10 + dig[3]);
		f.second  = 7'(dig[4] * 10 + dig[5]);
		f.lat_deg = 7'(dig[6] * 10 + dig[7]);
		f.lat_min = 20'((dig[8] * 10 + dig[9]) * 10000 + dig[10] * 1000 + dig[11] * 100
			+ dig[12] * 10 + dig[13]);
		f.south   = south_seen;
		f.lon_deg = 10'(dig[14] * 100 + dig[15] * 10 + dig[16]);
		f.lon_min = 20'((dig[17] * 10 + dig[18]) * 10000 + dig[19] * 1000 + dig[20] * 100
			+ dig[21] * 10 + dig[22]);
		f.west    = west_seen;
		f.hdop    = dec_neg[DEC_HDOP] ? 14'd0 : 14'(dec_mag[DEC_HDOP]);
		a = int'(dec_mag[DEC_ALT]);
		g = int'(dec_mag[DEC_GEOID]);
		if (dec_neg[DEC_ALT])
			a = -a;
		if (dec_neg[DEC_GEOID])
			g = -g;
		f.alt   = a[20:0];
		f.geoid = g[17:0];
		return f;
	endfunction

	task automatic clear_fix_data();
		for (int i = 0; i < 26; i++)
			dig[i] = 4'd0;
		for (int k = 0; k < 3; k++) begin
			dec_mag[k] = 0;
			dec_neg[k] = 1'b0;
			dec_point[k] = 1'b0;
			dec_done[k] = 1'b0;
		end
		south_seen = 1'b0;
		west_seen = 1'b0;
		field_idx = 0;
		char_idx = 0;
	endtask

	// signed decimal in tenths: sign at char 0, digits, point, one tenths digit
	task automatic take_decimal(input int k, input logic [7:0] b, input int unsigned pos);
		bit          isd;
		int unsigned v;
		isd = (b >= CHR_ZERO && b <= CHR_NINE);
		if (dec_done[k])
			return;
		if (pos == 0 && (b == CHR_MINUS || b == CHR_PLUS)) begin
			if (b == CHR_MINUS)
				dec_neg[k] = 1'b1;
		end else if (dec_point[k]) begin
			if (isd) begin
				v = dec_mag[k] + digit_val(b);
				dec_mag[k] = (v > dec_cap(k)) ? dec_cap(k) : v;
			end
			dec_done[k] = 1'b1;
		end else if (b == CHR_DOT) begin
			dec_point[k] = 1'b1;
		end else if (isd) begin
			v = dec_mag[k] * 10 + digit_val(b) * 10;
			dec_mag[k] = (v > dec_cap(k)) ? dec_cap(k) : v;
		end else begin
			dec_done[k] = 1'b1;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int unsigned pos;
		if (b == CHR_DOLLAR) begin
			clear_fix_data();
			phase = IN_HEADER;
			hdr_pos = 1;
			return;
		end
		case (phase)
			IN_HEADER: begin
				// the byte after the tag is taken as the separator, whatever it is
				if (hdr_pos >= 6) begin
					phase = IN_BODY;
					hdr_pos = 0;
				end else if (b == GGA_TAG[47 - 8 * hdr_pos -: 8]) begin
					hdr_pos++;
				end else begin
					phase = WAIT_DOLLAR;
					hdr_pos = 0;
				end
			end
			IN_BODY: begin
				if (b == CHR_STAR) begin
					fix_q.push_back(current_fix());
					fixes_made++;
					phase = WAIT_DOLLAR;
				end else if (b == CHR_COMMA) begin
					if (field_idx < FLD_LAST)
						field_idx++;
					char_idx = 0;
				end else if (char_idx < CHAR_CAP) begin
					pos = char_idx;
					char_idx++;
					case (field_idx)
						FLD_TIME: begin
							if (pos < 6)
								dig[pos] = digit_val(b);
						end
						FLD_LAT: begin
							if (pos < 4)
								dig[6 + pos] = digit_val(b);
							else if (pos >= 5 && pos <= 8)
								dig[5 + pos] = digit_val(b);
						end
						FLD_NS: begin
							if (pos == 0 && b == CHR_S)
								south_seen = 1'b1;
						end
						FLD_LON: begin
							if (pos < 5)
								dig[14 + pos] = digit_val(b);
							else if (pos >= 6 && pos <= 9)
								dig[13 + pos] = digit_val(b);
						end
						FLD_EW: begin
							if (pos == 0 && b == CHR_W)
								west_seen = 1'b1;
						end
						FLD_HDOP:  take_decimal(DEC_HDOP, b, pos);
						FLD_ALT:   take_decimal(DEC_ALT, b, pos);
						FLD_GEOID: take_decimal(DEC_GEOID, b, pos);
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	endtask

	task automatic note_error(input string what);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("ERROR cycle %0d: %s", cycle_count, what);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(posedge clk);
		end while (in_stall);
		bytes_sent++;
		decode_byte(b);
	endtask

	task automatic flush_line();
		while (line_q.size() > 0)
			send_byte(line_q.pop_front());
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	// mostly digits, now and then a non-digit character in a digit slot
	task automatic add_digits(input int n);
		repeat (n) begin
			if ($urandom_range(0, 49) == 0)
				line_q.push_back(8'($urandom_range(8'h41, 8'h7A)));
			else
				line_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	task automatic add_decimal(input int max_int);
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			line_q.push_back(CHR_MINUS);
		else if (r < 18)
			line_q.push_back(CHR_PLUS);
		add_digits($urandom_range(0, max_int));
		if ($urandom_range(0, 9) < 8) begin
			line_q.push_back(CHR_DOT);
			add_digits($urandom_range(0, 3));
		end
		r = $urandom_range(0, 39);
		if (r == 0)
			line_q.push_back(CHR_DOT);
		else if (r == 1)
			line_q.push_back(CHR_MINUS);
		else if (r == 2)
			add_text("x5");
	endtask

	task automatic add_hemi(input logic [7:0] a, input logic [7:0] b);
		case ($urandom_range(0, 5))
			0, 1: line_q.push_back(a);
			2, 3: line_q.push_back(b);
			4: line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
			default: ;
		endcase
	endtask

	task automatic add_gga(input bit closed);
		int r;
		add_text("$GPGGA,");
		if ($urandom_range(0, 9) != 0) begin
			add_digits(6);
			if ($urandom_range(0, 1))
				add_text(".");
			add_digits($urandom_range(0, 2));
		end
		add_text(",");
		r = $urandom_range(0, 19);
		if (r == 0) begin
			add_digits(20);
		end else if (r > 1) begin
			add_digits(4);
			add_text(".");
			add_digits($urandom_range(0, 6));
		end
		add_text(",");
		add_hemi("N", "S");
		add_text(",");
		r = $urandom_range(0, 19);
		if (r == 0) begin
			add_digits(22);
		end else if (r > 1) begin
			add_digits(5);
			add_text(".");
			add_digits($urandom_range(0, 6));
		end
		add_text(",");
		add_hemi("E", "W");
		add_text(",");
		add_digits(1);
		add_text(",");
		add_digits(2);
		add_text(",");
		if ($urandom_range(0, 29) == 0)
			line_q.push_back(CHR_CR);
		add_decimal(4);
		add_text(",");
		add_decimal(7);
		add_text(",M,");
		add_decimal(6);
		add_text(",M,");
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(3, 10)) begin
				add_text(",");
				add_digits($urandom_range(0, 3));
			end
		end else begin
			add_text(",");
		end
		if ($urandom_range(0, 19) == 0)
			add_text("\r\n");
		if (closed) begin
			add_text("*");
			add_digits(2);
			add_text("\r\n");
		end
	endtask

	// receiver: random stall runs, or a forced long hold-off
	always @(negedge clk) begin
		if (holding) begin
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run--;
		end else begin
			out_stall <= 1'b0;
			stall_run = idle_len();
		end
	end

	always begin
		@(hold_go);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d fixes outstanding", cycle_count,
				fix_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// every fix transfer is compared with the oldest predicted fix
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_fix = {utc_hour, utc_minute, utc_second, lat_degrees, lat_minutes_e4, lat_south,
				lon_degrees, lon_minutes_e4, lon_west, hdop_tenths, altitude_tenths,
				geoid_tenths};
			fixes_seen++;
			if (fix_q.size() == 0) begin
				note_error({"fix with none expected: ", fix_text(got_fix)});
			end else begin
				want_fix = fix_q.pop_front();
				bad_fields = "";
				if (got_fix.hour !== want_fix.hour)       bad_fields = {bad_fields, " utc_hour"};
				if (got_fix.minute !== want_fix.minute)   bad_fields = {bad_fields, " utc_minute"};
				if (got_fix.second !== want_fix.second)   bad_fields = {bad_fields, " utc_second"};
				if (got_fix.lat_deg !== want_fix.lat_deg) bad_fields = {bad_fields, " lat_degrees"};
				if (got_fix.lat_min !== want_fix.lat_min) bad_fields = {bad_fields, " lat_minutes"};
				if (got_fix.south !== want_fix.south)     bad_fields = {bad_fields, " lat_south"};
				if (got_fix.lon_deg !== want_fix.lon_deg) bad_fields = {bad_fields, " lon_degrees"};
				if (got_fix.lon_min !== want_fix.lon_min) bad_fields = {bad_fields, " lon_minutes"};
				if (got_fix.west !== want_fix.west)       bad_fields = {bad_fields, " lon_west"};
				if (got_fix.hdop !== want_fix.hdop)       bad_fields = {bad_fields, " hdop"};
				if (got_fix.alt !== want_fix.alt)         bad_fields = {bad_fields, " altitude"};
				if (got_fix.geoid !== want_fix.geoid)     bad_fields = {bad_fields, " geoid"};
				if (bad_fields != "")
					note_error({"fix differs in", bad_fields, "\n  expected ", fix_text(want_fix),
						"\n  actual   ", fix_text(got_fix)});
			end
		end
	end

	task automatic test_directed_fields();
		idling = 1'b0;
		// top of every range, hdop landing exactly on its limit, altitude and geoid one tenth below theirs
		add_text("$GPGGA,995959.99,9959.9999,S,99959.9999,W,8,12,999.9,99999.9,M,9999.9,M,,*00\r\n");
		// all zeros, negative zero
		add_text("$GPGGA,000000,0000.0000,N,00000.0000,E,0,00,0.0,-0.0,M,-0.0,M,,*00\r\n");
		// every field empty
		add_text("$GPGGA,,,,,,,,,,,,,,*00\r\n");
		// non-digits in digit slots, lowercase hemispheres, saturation both ways
		add_text("$GPGGA,12a4:6,4x07.1b38,s,0z112.3-44,w,1,05,12345.6,-1234567.8,M,+100000.5,M,,*0\r\n");
		// negative hdop, second point, extra fraction digits truncated
		add_text("$GPGGA,1,2,S,3,W,0,0,-1.5,1.2.3,M,7.891,M,,*00\r\n");
		// sign not at the first char ends the number
		add_text("$GPGGA,123456,1234.5678,N,01234.5678,E,1,08,0-9,1-5,M,,M,,*00\r\n");
		// fields longer than the kept prefix
		add_text("$GPGGA,,,,,,,,0000000000000000009,0000000000000001.5,M,,M,,*00\r\n");
		// more commas than the field counter holds
		add_text("$GPGGA,010203,,,,,,,1.0,2.0,M,3.0,,,,,,,,,,,,,,,,,,,,,,4*00\r\n");
		flush_line();
	endtask

	task automatic test_header_and_framing();
		idling = 1'b0;
		// ignored while idle, including all-zero and all-one bytes
		line_q.push_back(8'h00);
		line_q.push_back(8'hFF);
		line_q.push_back(8'h80);
		line_q.push_back(8'h7F);
		add_text("*,GPGGA,1*");
		// wrong sentence, wrong case
		add_text("$GPRMC,123456,,,,,,*00\r\n$gpgga,1*\r\n$GPGG*,1*");
		// dollar inside the header restarts it
		add_text("$GPGG$GPGGA,111111,*00\r\n");
		// unfinished sentence is dropped at the next dollar
		add_text("$GPGGA,222222,1111.1111$GPGGA,333333*00\r\n");
		// separator after the tag need not be a comma
		add_text("$GPGGAX123456,,S*");
		// CR and LF inside the body are ordinary chars; a second star is ignored
		add_text("$GPGGA,121212,\r\n12.3456,,,W*");
		add_text("*\r\n");
		flush_line();
	endtask

	// output held off while short sentences keep coming, so input must back up
	task automatic test_backpressure();
		idling = 1'b0;
		->hold_go;
		repeat (6) begin
			add_text("$GPGGA,");
			add_digits(6);
			add_text(",,,,,,,");
			add_decimal(3);
			add_text("*");
			flush_line();
		end
	endtask

	task automatic test_random_sentences();
		int start_fixes, rnd_bytes, kind, keep;
		start_fixes = fixes_made;
		rnd_bytes = 0;
		while (rnd_bytes < RANDOM_BYTES || fixes_made - start_fixes < RANDOM_FIXES) begin
			idling = ($urandom_range(0, 9) < 8);
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				add_gga(1'b1);
			end else if (kind < 85) begin
				add_gga(1'b0);
				keep = $urandom_range(1, line_q.size());
				while (line_q.size() > keep)
					line_q.delete(line_q.size() - 1);
			end else if (kind < 92) begin
				add_text("$GPGGA");
				line_q[$urandom_range(1, 5)] = 8'($urandom_range(8'h41, 8'h5A));
				add_text(",123456,4807.038,N*00\r\n");
			end else begin
				repeat ($urandom_range(1, 12))
					line_q.push_back(8'($urandom_range(0, 255)));
			end
			if (kind < 92)
				rnd_bytes += line_q.size();
			flush_line();
		end
	endtask

	initial begin
		phase = WAIT_DOLLAR;
		hdr_pos = 0;
		clear_fix_data();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_fields();
		test_header_and_framing();
		test_backpressure();
		test_random_sentences();

		@(negedge clk);
		in_valid <= 1'b0;
		while (fix_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes of headers, bodies and noise; %0d fixes decoded and compared",
			bytes_sent, fixes_seen);
		$display("with one %0d-cycle output hold-off, random gaps on both sides, %0d errors",
			HOLD_CYCLES, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
